/* rtl/aes_pkg.sv */
// aes_pkg: shared types, constants and byte functions for the aes-128 encryptor
// holds the s-box table, the rcon sequence and the config register indexes
// no dependencies
`default_nettype none

package aes_pkg;

  localparam int unsigned HALF_W     = 64;
  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned ROUND_KEYS = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [3:0]         round_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } cfg_reg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  // round constant for key schedule step n (n = 1..10)
  function automatic logic [7:0] rcon(input round_t n);
    logic [7:0] r;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

/* rtl/aes_if.sv */
// aes_if: valid/ready channel interfaces for the aes-128 encryptor
// plaintext request, ciphertext result and key register write channels
// depends on aes_pkg
`default_nettype none

interface aes_plain_if;
  logic           valid;
  logic           ready;
  aes_pkg::half_t plain_high;
  aes_pkg::half_t plain_low;
  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface aes_cipher_if;
  logic           valid;
  logic           ready;
  aes_pkg::half_t cipher_high;
  aes_pkg::half_t cipher_low;
  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface aes_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aes_pkg::CFG_IDX_W-1:0]    index;
  aes_pkg::half_t                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/aes_round.sv */
// aes_round: one aes round, subbytes, shiftrows, optional mixcolumns, addroundkey
// combinational, reused for every round by the top level sequencer
// depends on aes_pkg
`default_nettype none

module aes_round (
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t rkey_i,
  input  logic            final_i,
  output aes_pkg::block_t state_o
);

  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [7:0] a0, a1, a2, a3;

  // byte i sits at bits 127-8i downto 120-8i; column c holds bytes 4c..4c+3
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c+r] = aes_pkg::sbox(state_i[127 - 8*(4*((c + r) % 4) + r) -: 8]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c+1];
      a2 = sb[4*c+2];
      a3 = sb[4*c+3];
      mx[4*c]   = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
      mx[4*c+1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
      mx[4*c+2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
      mx[4*c+3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      state_o[127 - 8*i -: 8] = (final_i ? sb[i] : mx[i]) ^ rkey_i[127 - 8*i -: 8];
    end
  end

endmodule

`default_nettype wire

/* rtl/aes128_block_encrypt.sv */
// aes128_block_encrypt: iterative aes-128 encryptor with a stored key schedule
// usage:
//   in_if  carries a plaintext block (plain_high holds bytes 0..7), taken when
//          valid and ready are both high; ready is high only while idle
//   out_if carries the ciphertext block from an output register, held until
//          the receiver takes it with ready
//   cfg_if writes key_high (index 0) or key_low (index 1); a write to either
//          re-expands the key, other indexes are ignored; ready only while idle
// timing:
//   the initial key addition is applied as the request is taken, then each
//   round runs in turn through the single round unit, and the last round
//   loads the output register; ready returns with the result, so the next
//   request is not taken until the current block has finished its rounds
//   a key write runs the expansion, one round key per cycle
// reset:
//   both key registers clear and the all-zero key is expanded, during which
//   no request or key write is taken
// stall:
//   a new block may start while a result waits; if the result is still not
//   taken when the last round finishes, the block holds its last round
`default_nettype none

module aes128_block_encrypt (
  input  logic                clk,
  input  logic                rst_n,
  aes_plain_if.sink           in_if,
  aes_cipher_if.source        out_if,
  aes_cfg_if.sink             cfg_if
);

  typedef enum logic [2:0] {
    ST_KEYX  = 3'b001,
    ST_IDLE  = 3'b010,
    ST_ROUND = 3'b100
  } state_t;

  localparam aes_pkg::round_t LAST_ROUND = 4'd10;

  state_t          state_r, state_nxt;
  aes_pkg::round_t kcnt_r, kcnt_nxt;
  aes_pkg::round_t rnd_r, rnd_nxt;
  aes_pkg::half_t  key_high_r, key_low_r;
  aes_pkg::block_t kw_r, kw_nxt;
  aes_pkg::block_t rkey_r [aes_pkg::ROUND_KEYS];
  aes_pkg::block_t st_r;
  aes_pkg::block_t round_out;
  aes_pkg::half_t  cipher_high_r, cipher_low_r;
  logic            out_valid_r;
  logic            last_round;
  logic            slot_free;
  logic            cfg_req, in_req, cfg_key;

  // next round key from the previous one
  function automatic aes_pkg::block_t key_step(input aes_pkg::block_t k,
                                               input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {aes_pkg::sbox(k[23:16]) ^ rc, aes_pkg::sbox(k[15:8]),
          aes_pkg::sbox(k[7:0]), aes_pkg::sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  aes_round u_round (
    .state_i (st_r),
    .rkey_i  (rkey_r[rnd_r]),
    .final_i (last_round),
    .state_o (round_out)
  );

  assign cfg_if.ready = (state_r == ST_IDLE);
  assign in_if.ready  = (state_r == ST_IDLE) && !cfg_if.valid;
  assign cfg_req      = cfg_if.valid && cfg_if.ready;
  assign in_req       = in_if.valid && in_if.ready;
  assign cfg_key      = (cfg_if.index == aes_pkg::REG_KEY_HIGH) ||
                        (cfg_if.index == aes_pkg::REG_KEY_LOW);
  assign last_round   = (rnd_r == LAST_ROUND);
  assign slot_free    = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.cipher_high = cipher_high_r;
  assign out_if.cipher_low  = cipher_low_r;

  always_comb begin
    kw_nxt = (kcnt_r == 4'd0) ? {key_high_r, key_low_r}
                              : key_step(kw_r, aes_pkg::rcon(kcnt_r));
  end

  always_comb begin
    state_nxt = state_r;
    kcnt_nxt  = kcnt_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      ST_KEYX: begin
        kcnt_nxt = kcnt_r + 4'd1;
        if (kcnt_r == LAST_ROUND) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_req && cfg_key) begin
          state_nxt = ST_KEYX;
          kcnt_nxt  = 4'd0;
        end else if (in_req) begin
          state_nxt = ST_ROUND;
          rnd_nxt   = 4'd1;
        end
      end
      ST_ROUND: begin
        if (!last_round) begin
          rnd_nxt = rnd_r + 4'd1;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_KEYX;
        kcnt_nxt  = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KEYX;
      kcnt_r      <= 4'd0;
      rnd_r       <= 4'd0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kcnt_r  <= kcnt_nxt;
      rnd_r   <= rnd_nxt;
      if (cfg_req && (cfg_if.index == aes_pkg::REG_KEY_HIGH)) begin
        key_high_r <= cfg_if.data;
      end
      if (cfg_req && (cfg_if.index == aes_pkg::REG_KEY_LOW)) begin
        key_low_r <= cfg_if.data;
      end
      if ((state_r == ST_ROUND) && last_round && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_KEYX) begin
      kw_r           <= kw_nxt;
      rkey_r[kcnt_r] <= kw_nxt;
    end
    if (in_req) begin
      st_r <= {in_if.plain_high, in_if.plain_low} ^ rkey_r[0];
    end else if ((state_r == ST_ROUND) && !last_round) begin
      st_r <= round_out;
    end
    if ((state_r == ST_ROUND) && last_round && slot_free) begin
      cipher_high_r <= round_out[127:64];
      cipher_low_r  <= round_out[63:0];
    end
  end

endmodule

`default_nettype wire
